// ----- src/cdm_pkg.sv -----
`timescale 1ns / 1ps

package cdm_pkg;

   localparam int DataW  = 16;
   localparam int CfgW   = 15;
   localparam int AccW   = 17;
   localparam int DriveW = 18;
   localparam int AddrW  = 3;
   localparam int BusW   = 32;

   // register index codes, decoded from paddr[2]
   localparam logic REG_FILTER_GAIN    = 1'b0;
   localparam logic REG_TURN_THRESHOLD = 1'b1;

   localparam logic [CfgW-1:0] FILTER_GAIN_RST    = 15'd1638;
   localparam logic [CfgW-1:0] TURN_THRESHOLD_RST = 15'd3277;

   localparam logic signed [22:0] ONE_Q14  = 23'sd16384;
   localparam logic signed [22:0] OUT_LIM  = 23'sd65536;
   localparam logic signed [21:0] ACC_MAX  = 22'sd65535;
   localparam logic signed [21:0] ACC_MIN  = -22'sd65536;
   localparam logic signed [35:0] HALF_Q14 = 36'sd8192;

   typedef struct packed {
      logic [CfgW-1:0] filter_gain;
      logic [CfgW-1:0] turn_threshold;
   } cfg_type;

endpackage

// ----- src/cdm_csr.sv -----
`timescale 1ns / 1ps

module cdm_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [cdm_pkg::AddrW-1:0]  csr_paddr,
   input  logic [cdm_pkg::BusW-1:0]   csr_pwdata,
   output logic [cdm_pkg::BusW-1:0]   csr_prdata,
   output logic                       csr_pready,
   output cdm_pkg::cfg_type           cfg
);

   cdm_pkg::cfg_type cfg_ff;
   cdm_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            cdm_pkg::REG_FILTER_GAIN:    cfg_in.filter_gain    = csr_pwdata[cdm_pkg::CfgW-1:0];
            cdm_pkg::REG_TURN_THRESHOLD: cfg_in.turn_threshold = csr_pwdata[cdm_pkg::CfgW-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         cdm_pkg::REG_FILTER_GAIN:
            csr_prdata = {{(cdm_pkg::BusW-cdm_pkg::CfgW){1'b0}}, cfg_ff.filter_gain};
         cdm_pkg::REG_TURN_THRESHOLD:
            csr_prdata = {{(cdm_pkg::BusW-cdm_pkg::CfgW){1'b0}}, cfg_ff.turn_threshold};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_gain    <= cdm_pkg::FILTER_GAIN_RST;
         cfg_ff.turn_threshold <= cdm_pkg::TURN_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/cdm_mix.sv -----
`timescale 1ns / 1ps

module cdm_mix (
   input  logic signed [cdm_pkg::DataW-1:0]  throttle,
   input  logic signed [cdm_pkg::DataW-1:0]  rotation,
   input  logic                              quick_turn,
   input  logic signed [cdm_pkg::AccW-1:0]   acc,
   input  cdm_pkg::cfg_type                  cfg,
   output logic signed [cdm_pkg::DriveW-1:0] left_drive,
   output logic signed [cdm_pkg::DriveW-1:0] right_drive,
   output logic signed [cdm_pkg::AccW-1:0]   acc_next
);

   logic signed [16:0] abs_y;
   logic signed [15:0] rot_clamp;
   logic signed [18:0] diff;
   logic signed [16:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [35:0] prod;
   logic signed [35:0] prod_r;
   logic signed [21:0] rnd;
   logic signed [21:0] acc_filt;
   logic signed [22:0] turn;
   logic signed [22:0] left_mix;
   logic signed [22:0] right_mix;
   logic signed [22:0] left_clip;
   logic signed [22:0] right_clip;
   logic               below_thr;

   always_comb begin
      abs_y = throttle[15] ? -{throttle[15], throttle} : {throttle[15], throttle};

      if (rotation > 16'sd16384)       rot_clamp = 16'sd16384;
      else if (rotation < -16'sd16384) rot_clamp = -16'sd16384;
      else                             rot_clamp = rotation;

      // acc' = acc + round(g * (target - acc)), target = 2 * clamped rotation
      diff = {{2{rot_clamp[15]}}, rot_clamp, 1'b0} - {{2{acc[16]}}, acc};

      // one shared multiplier: filter step in quick-turn mode, |y|*rot otherwise
      mul_a  = quick_turn ? {2'b00, cfg.filter_gain} : abs_y;
      mul_b  = quick_turn ? diff : {{3{rotation[15]}}, rotation};
      prod   = 36'(mul_a) * 36'(mul_b);
      prod_r = prod + cdm_pkg::HALF_Q14;
      rnd    = prod_r[35:14];

      below_thr = abs_y < $signed({2'b00, cfg.turn_threshold});

      acc_filt = {{5{acc[16]}}, acc} + rnd;
      if (acc_filt > cdm_pkg::ACC_MAX)      acc_filt = cdm_pkg::ACC_MAX;
      else if (acc_filt < cdm_pkg::ACC_MIN) acc_filt = cdm_pkg::ACC_MIN;

      if (quick_turn) begin
         turn     = {{7{rotation[15]}}, rotation};
         acc_next = below_thr ? acc_filt[16:0] : acc;
      end else begin
         turn = {rnd[21], rnd} - {{6{acc[16]}}, acc};
         // step one unit toward zero, clear inside the unit band
         if (acc > 17'sd16384)
            acc_next = acc - 17'sd16384;
         else if (acc < -17'sd16384)
            acc_next = acc + 17'sd16384;
         else
            acc_next = '0;
      end

      left_mix  = {{7{throttle[15]}}, throttle} + turn;
      right_mix = {{7{throttle[15]}}, throttle} - turn;

      left_clip  = left_mix;
      right_clip = right_mix;
      // in quick-turn mode, move the first overpowered side's excess to the other side
      if (quick_turn) begin
         if (left_mix > cdm_pkg::ONE_Q14) begin
            right_clip = right_mix - (left_mix - cdm_pkg::ONE_Q14);
            left_clip  = cdm_pkg::ONE_Q14;
         end else if (right_mix > cdm_pkg::ONE_Q14) begin
            left_clip  = left_mix - (right_mix - cdm_pkg::ONE_Q14);
            right_clip = cdm_pkg::ONE_Q14;
         end else if (left_mix < -cdm_pkg::ONE_Q14) begin
            right_clip = right_mix - (left_mix + cdm_pkg::ONE_Q14);
            left_clip  = -cdm_pkg::ONE_Q14;
         end else if (right_mix < -cdm_pkg::ONE_Q14) begin
            left_clip  = left_mix - (right_mix + cdm_pkg::ONE_Q14);
            right_clip = -cdm_pkg::ONE_Q14;
         end
      end

      if (left_clip > cdm_pkg::OUT_LIM)       left_clip = cdm_pkg::OUT_LIM;
      else if (left_clip < -cdm_pkg::OUT_LIM) left_clip = -cdm_pkg::OUT_LIM;
      if (right_clip > cdm_pkg::OUT_LIM)       right_clip = cdm_pkg::OUT_LIM;
      else if (right_clip < -cdm_pkg::OUT_LIM) right_clip = -cdm_pkg::OUT_LIM;

      left_drive  = left_clip[cdm_pkg::DriveW-1:0];
      right_drive = right_clip[cdm_pkg::DriveW-1:0];
   end

endmodule

// ----- src/curvature_drive_mixer_top.sv -----
`timescale 1ns / 1ps

// Curvature drive mixer with quick-stop accumulator.
// Input channel (req_*): one word carries throttle, rotation (signed Q2.14)
// and the quick-turn flag; taken when req_valid is high and req_stall low.
// Result channel (rsp_*): one word per input word with the left and right
// drive commands, signed Q4.14, saturated to +-4.0.
// Configuration (csr_*): APB-style writes to filter_gain at address 0 and
// turn_threshold at address 4; pready is always high.
// A taken word waits in the input register, then passes the mixer into
// the output register on rsp_*. Throughput: one word per cycle while
// rsp_stall is low; the quick-stop accumulator is updated when its word
// moves to the output register, through one shared multiplier.
// Reset clears both valid flags and the accumulator and restores the
// register defaults (filter_gain 1638, turn_threshold 3277).
// When the receiver stalls, the output word holds and one more word is
// taken into the input register; after that req_stall rises until the
// output word is taken.

module curvature_drive_mixer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [cdm_pkg::DataW-1:0]    req_throttle,
   input  logic signed [cdm_pkg::DataW-1:0]    req_rotation,
   input  logic                                req_quick_turn,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cdm_pkg::DriveW-1:0]   rsp_left_drive,
   output logic signed [cdm_pkg::DriveW-1:0]   rsp_right_drive,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cdm_pkg::AddrW-1:0]           csr_paddr,
   input  logic [cdm_pkg::BusW-1:0]            csr_pwdata,
   output logic [cdm_pkg::BusW-1:0]            csr_prdata,
   output logic                                csr_pready
);

   cdm_pkg::cfg_type                   cfg;

   logic                               s1_vld_ff, s1_vld_in;
   logic signed [cdm_pkg::DataW-1:0]   s1_y_ff, s1_rot_ff;
   logic                               s1_quick_ff;
   logic                               rsp_vld_ff, rsp_vld_in;
   logic signed [cdm_pkg::DriveW-1:0]  left_ff, right_ff;
   logic signed [cdm_pkg::DriveW-1:0]  left_in, right_in;
   logic signed [cdm_pkg::AccW-1:0]    acc_ff, acc_in;
   logic                               load, adv;

   cdm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cdm_mix u_mix (
      .throttle    (s1_y_ff),
      .rotation    (s1_rot_ff),
      .quick_turn  (s1_quick_ff),
      .acc         (acc_ff),
      .cfg         (cfg),
      .left_drive  (left_in),
      .right_drive (right_in),
      .acc_next    (acc_in)
   );

   assign adv       = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !adv;
   assign load      = req_valid && !req_stall;

   assign s1_vld_in  = load ? 1'b1 : (adv ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = adv ? 1'b1 : (rsp_stall ? rsp_vld_ff : 1'b0);

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (adv) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_y_ff     <= req_throttle;
         s1_rot_ff   <= req_rotation;
         s1_quick_ff <= req_quick_turn;
      end
      if (adv) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(acc_ff))
      else $error("accumulator changed without an advancing word");

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_vld_ff)
      else $error("accepted word not held in input register");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s1_vld_ff))
      else $error("result appeared without an input word");

   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_stall && !adv |=> !rsp_vld_ff)
      else $error("taken result word repeated");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam longint Q14_ONE  = 16384;
   localparam longint Q14_HALF = 8192;
   localparam longint ACC_HI   = 65535;
   localparam longint ACC_LO   = -65536;
   localparam longint DRIVE_LIM = 65536;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     RANDOM_PER_SETTING = 160;
   localparam int     SETTING_COUNT = 6;

   typedef struct packed {
      logic signed [cdm_pkg::DriveW-1:0] left;
      logic signed [cdm_pkg::DriveW-1:0] right;
   } drive_pair_type;

   typedef struct packed {
      logic signed [cdm_pkg::DataW-1:0]  thr;
      logic signed [cdm_pkg::DataW-1:0]  rot;
      logic                              quick;
      logic                              fixed;
      logic signed [cdm_pkg::DriveW-1:0] left;
      logic signed [cdm_pkg::DriveW-1:0] right;
   } stim_row_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic signed [cdm_pkg::DataW-1:0]   req_throttle;
   logic signed [cdm_pkg::DataW-1:0]   req_rotation;
   logic                               req_quick_turn;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [cdm_pkg::DriveW-1:0]  rsp_left_drive;
   logic signed [cdm_pkg::DriveW-1:0]  rsp_right_drive;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [cdm_pkg::AddrW-1:0]          csr_paddr;
   logic [cdm_pkg::BusW-1:0]           csr_pwdata;
   logic [cdm_pkg::BusW-1:0]           csr_prdata;
   logic                               csr_pready;

   // predictor state and register copies
   longint    stop_acc;
   longint    gain_q14;
   longint    turn_bound;
   longint    acc_peak;

   drive_pair_type expected_drives[$];
   int        words_sent;
   int        drives_checked;
   int        quick_words;
   int        mismatches;
   int        cycles;
   logic      calm;
   stim_row_type directed_rows[22];

   curvature_drive_mixer_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   assign calm = (words_sent >= 400) && (words_sent < 560);

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint round_q14(input longint v);
      return (v + Q14_HALF) >>> 14;
   endfunction

   // Advance the quick-stop accumulator and mix one word into left/right drive.
   function automatic drive_pair_type mix_drive(input logic signed [cdm_pkg::DataW-1:0] thr,
                                                input logic signed [cdm_pkg::DataW-1:0] rot,
                                                input logic quick);
      longint    y, r, ay, acc, turn, lt, rt;
      drive_pair_type res;
      y   = longint'(thr);
      r   = longint'(rot);
      ay  = (y < 0) ? -y : y;
      acc = stop_acc;
      if (quick) begin
         if (ay < turn_bound)
            acc = clip(round_q14((Q14_ONE - gain_q14) * acc
                                 + gain_q14 * 2 * clip(r, -Q14_ONE, Q14_ONE)), ACC_LO, ACC_HI);
         turn = r;
      end else begin
         turn = round_q14(ay * r) - acc;
         if (acc > Q14_ONE) acc = acc - Q14_ONE;
         else if (acc < -Q14_ONE) acc = acc + Q14_ONE;
         else acc = 0;
      end
      stop_acc = acc;
      if (((acc < 0) ? -acc : acc) > acc_peak) acc_peak = (acc < 0) ? -acc : acc;
      lt = y + turn;
      rt = y - turn;
      // in quick-turn mode clip the first overpowered side, shift its excess across
      if (quick) begin
         if (lt > Q14_ONE) begin
            rt = rt - (lt - Q14_ONE);
            lt = Q14_ONE;
         end else if (rt > Q14_ONE) begin
            lt = lt - (rt - Q14_ONE);
            rt = Q14_ONE;
         end else if (lt < -Q14_ONE) begin
            rt = rt - (lt + Q14_ONE);
            lt = -Q14_ONE;
         end else if (rt < -Q14_ONE) begin
            lt = lt - (rt + Q14_ONE);
            rt = -Q14_ONE;
         end
      end
      res.left  = 18'(clip(lt, -DRIVE_LIM, DRIVE_LIM));
      res.right = 18'(clip(rt, -DRIVE_LIM, DRIVE_LIM));
      return res;
   endfunction

   task automatic send_word(input stim_row_type w);
      drive_pair_type p;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_throttle   <= w.thr;
      req_rotation   <= w.rot;
      req_quick_turn <= w.quick;
      do @(posedge clock); while (req_stall);
      p = mix_drive(w.thr, w.rot, w.quick);
      if (w.fixed) begin
         p.left  = w.left;
         p.right = w.right;
      end
      expected_drives.push_back(p);
      words_sent++;
      if (w.quick) quick_words++;
   endtask

   task automatic csr_write(input logic idx, input logic [cdm_pkg::BusW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == cdm_pkg::REG_FILTER_GAIN) gain_q14 = longint'(value[cdm_pkg::CfgW-1:0]);
      else turn_bound = longint'(value[cdm_pkg::CfgW-1:0]);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [cdm_pkg::DataW-1:0] edge_value();
      case ($urandom_range(6))
         0: return -16'sd32768;
         1: return -16'sd16384;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         5: return 16'sd16384;
         default: return 16'sd32767;
      endcase
   endfunction

   function automatic stim_row_type random_word(input logic quick);
      stim_row_type w;
      int      sel, mag;
      w.fixed = 1'b0;
      w.left  = '0;
      w.right = '0;
      w.quick = quick;
      sel = $urandom_range(99);
      if (sel < 10) w.thr = edge_value();
      else if (sel < 50) begin
         // hover around the threshold so the accumulator keeps moving
         mag = $urandom_range(0, int'((turn_bound + 2 > 32767) ? 32767 : turn_bound + 2));
         w.thr = 16'($urandom_range(1) ? -mag : mag);
      end else if (sel < 90) w.thr = 16'($signed($urandom_range(0, 32768)) - 16384);
      else w.thr = 16'($urandom);
      sel = $urandom_range(99);
      if (sel < 15) w.rot = edge_value();
      else if (sel < 85) w.rot = 16'($signed($urandom_range(0, 32768)) - 16384);
      else w.rot = 16'($urandom);
      return w;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected drive word: left %0d right %0d",
                        rsp_left_drive, rsp_right_drive);
         end else begin
            drive_pair_type e;
            e = expected_drives.pop_front();
            drives_checked++;
            if (rsp_left_drive !== e.left || rsp_right_drive !== e.right) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("drive mismatch at word %0d: expected %0d/%0d, got %0d/%0d",
                           drives_checked, e.left, e.right, rsp_left_drive, rsp_right_drive);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 22);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycles, expected_drives.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int   gains[SETTING_COUNT];
      int   bounds[SETTING_COUNT];
      logic quick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_throttle   = '0;
      req_rotation   = '0;
      req_quick_turn = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      stop_acc       = 0;
      gain_q14       = 1638;
      turn_bound     = 3277;
      acc_peak       = 0;
      words_sent     = 0;
      drives_checked = 0;
      quick_words    = 0;
      mismatches     = 0;
      cycles         = 0;

      // thr, rot, quick, fixed, left, right; fixed rows assume a cleared accumulator
      directed_rows = '{
         '{16'sd0,      16'sd0,      1'b0, 1'b1, 18'sd0,      18'sd0},
         '{16'sd16384,  16'sd0,      1'b0, 1'b1, 18'sd16384,  18'sd16384},
         '{16'sd16384,  16'sd16384,  1'b0, 1'b1, 18'sd32768,  18'sd0},
         '{-16'sd16384, 16'sd16384,  1'b0, 1'b1, 18'sd0,      -18'sd32768},
         '{-16'sd32768, -16'sd32768, 1'b0, 1'b1, -18'sd65536, 18'sd32768},
         '{16'sd32767,  16'sd32767,  1'b0, 1'b1, 18'sd65536,  -18'sd32765},
         '{16'sd16384,  16'sd0,      1'b1, 1'b1, 18'sd16384,  18'sd16384},
         '{16'sd16384,  16'sd16384,  1'b1, 1'b1, 18'sd16384,  -18'sd16384},
         '{-16'sd16384, 16'sd16384,  1'b1, 1'b1, 18'sd16384,  -18'sd16384},
         '{16'sd32767,  -16'sd32768, 1'b1, 1'b1, -18'sd49152, 18'sd16384},
         '{-16'sd32768, 16'sd32767,  1'b1, 1'b1, 18'sd49150,  -18'sd16384},
         '{16'sd0,      16'sd16384,  1'b1, 1'b0, 18'sd0,      18'sd0},
         '{16'sd3276,   16'sd32767,  1'b1, 1'b0, 18'sd0,      18'sd0},
         '{16'sd0,      16'sd32767,  1'b1, 1'b0, 18'sd0,      18'sd0},
         '{16'sd3277,   16'sd0,      1'b1, 1'b0, 18'sd0,      18'sd0},
         '{-16'sd3276,  -16'sd32768, 1'b1, 1'b0, 18'sd0,      18'sd0},
         '{-16'sd3277,  16'sd100,    1'b1, 1'b0, 18'sd0,      18'sd0},
         '{16'sd0,      -16'sd16384, 1'b0, 1'b0, 18'sd0,      18'sd0},
         '{16'sd8192,   -16'sd8192,  1'b0, 1'b0, 18'sd0,      18'sd0},
         '{-16'sd1,     16'sd1,      1'b0, 1'b0, 18'sd0,      18'sd0},
         '{16'sd1,      -16'sd1,     1'b1, 1'b0, 18'sd0,      18'sd0},
         '{16'sd0,      16'sd0,      1'b0, 1'b0, 18'sd0,      18'sd0}
      };

      gains  = '{16384, 32767, 0,     1,     0, 1638};
      bounds = '{16384, 32767, 0, 32767,     0, 3277};
      gains[3]  = $urandom_range(1, 32766);
      bounds[4] = $urandom_range(1, 32766);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i]);

      for (int s = 0; s < SETTING_COUNT; s++) begin
         // hold off until the pipeline is empty before touching the registers
         @(negedge clock);
         req_valid <= 1'b0;
         wait_drained();
         csr_write(cdm_pkg::REG_FILTER_GAIN, gains[s]);
         csr_write(cdm_pkg::REG_TURN_THRESHOLD, bounds[s]);
         quick = $urandom_range(1);
         for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
            // keep quick-turn runs long so the accumulator builds and then unwinds
            if ($urandom_range(99) < 20) quick = ~quick;
            send_word(random_word(quick));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("sent %0d words (%0d quick-turn) over %0d register settings, %0d drives checked",
               words_sent, quick_words, SETTING_COUNT + 1, drives_checked);
      $display("largest quick-stop accumulator magnitude reached: %0d", acc_peak);
      if (mismatches == 0 && expected_drives.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d words never arrived", mismatches, expected_drives.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
